// ===== rtl/core/mrpp_pkg.sv =====
// Shared types and constants for the MQTT receive packet parser.
package mrpp_pkg;

    localparam int DIGIT_W      = 7;
    localparam int RESULT_DEPTH = 4;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [3:0] PKT_CONNACK = 4'd2;
    localparam logic [3:0] PKT_PUBLISH = 4'd3;
    localparam logic [3:0] PKT_SUBACK  = 4'd9;

    localparam logic [7:0] SUBACK_FAILURE = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_BODY
    } phase_t;

    typedef enum logic [3:0] {
        EV_TOPIC_BYTE      = 4'd0,
        EV_PAYLOAD_BYTE    = 4'd1,
        EV_MSG_END         = 4'd2,
        EV_PUBACK_REQ      = 4'd3,
        EV_CONNACK_OK      = 4'd4,
        EV_CONNACK_REFUSED = 4'd5,
        EV_SUBACK_GRANTED  = 4'd6,
        EV_SUBACK_REFUSED  = 4'd7,
        EV_BAD_LENGTH      = 4'd8,
        EV_BAD_CONNACK     = 4'd9
    } event_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [15:0] packet_id;
        logic [7:0]  code;
        logic        connected;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// ===== rtl/core/mrpp_parser.sv =====
// Parser state and the per-byte step logic that produces up to two results.
module mrpp_parser #(
    parameter int LENGTH_DIGITS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  mrpp_pkg::item_t        item,
    output mrpp_pkg::result_pair_t results
);
    import mrpp_pkg::*;

    localparam int RL_W  = DIGIT_W * LENGTH_DIGITS;
    localparam int CNT_W = $clog2(LENGTH_DIGITS + 1);
    localparam int CMP_W = ((RL_W > 18) ? RL_W : 18) + 1;

    phase_t            phase_reg, phase_next;
    logic [7:0]        header_reg, header_next;
    logic [RL_W-1:0]   rl_reg, rl_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RL_W-1:0]   pos_reg, pos_next;
    logic [15:0]       topic_reg, topic_next;
    logic [15:0]       pid_reg, pid_next;
    logic [7:0]        code_reg, code_next;
    logic              pub_ok_reg, pub_ok_next;
    logic              connected_reg, connected_next;
    logic              halted_reg, halted_next;

    logic              restart;
    logic              take_byte;
    logic [7:0]        rx;
    logic [3:0]        pkt_type;
    logic [1:0]        qos;
    logic [RL_W-1:0]   rl_digit;
    logic [CNT_W:0]    cnt_inc;
    logic              too_many;
    logic [RL_W:0]     pos_inc;
    logic              body_done;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  tend;
    logic [CMP_W-1:0]  tend_plus1;
    logic [CMP_W-1:0]  need;
    logic              finish;
    logic              body_ev_valid;
    logic              fin_ev_valid;
    result_t           body_ev;
    result_t           fin_ev;

    assign rx        = item.rx_byte;
    assign restart   = advance && (item.operation == OP_RESTART);
    assign take_byte = advance && (item.operation == OP_BYTE) && !halted_reg;
    assign pkt_type  = header_reg[7:4];
    assign qos       = header_reg[2:1];

    // Each length digit lands in its own 7-bit field, so placing it is enough.
    always_comb
    begin
        rl_digit = rl_reg;
        for (int d = 0; d < LENGTH_DIGITS; d++)
        begin
            if (cnt_reg == CNT_W'(d))
            begin
                rl_digit[DIGIT_W*d +: DIGIT_W] = rx[6:0];
            end
        end
    end

    assign cnt_inc    = (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(1);
    assign too_many   = rx[7] && (cnt_inc >= (CNT_W+1)'(LENGTH_DIGITS));
    assign pos_inc    = (RL_W+1)'(pos_reg) + (RL_W+1)'(1);
    assign body_done  = pos_inc >= (RL_W+1)'(rl_reg);
    assign pos_ext    = CMP_W'(pos_reg);
    assign tend       = CMP_W'(topic_reg) + CMP_W'(2);
    assign tend_plus1 = CMP_W'(topic_reg) + CMP_W'(3);
    assign need       = CMP_W'({topic_reg[15:8], rx}) + CMP_W'((qos != 2'd0) ? 4 : 2);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (restart)
        begin
            phase_next = PH_HEADER;
        end
        else if (take_byte)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (!rx[7])
                    begin
                        phase_next = (rl_digit == '0) ? PH_HEADER : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (body_done)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // Held fields, flags and the results of this byte.
    always_comb
    begin
        header_next    = header_reg;
        rl_next        = rl_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        topic_next     = topic_reg;
        pid_next       = pid_reg;
        code_next      = code_reg;
        pub_ok_next    = pub_ok_reg;
        connected_next = connected_reg;
        halted_next    = halted_reg;
        finish         = 1'b0;
        body_ev_valid  = 1'b0;
        fin_ev_valid   = 1'b0;
        body_ev        = '0;
        fin_ev         = '0;

        if (restart)
        begin
            connected_next = 1'b0;
            halted_next    = 1'b0;
        end
        else if (take_byte)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    header_next = rx;
                    rl_next     = '0;
                    cnt_next    = '0;
                    pos_next    = '0;
                    topic_next  = '0;
                    pid_next    = '0;
                    code_next   = '0;
                    pub_ok_next = 1'b0;
                end
                PH_LENGTH:
                begin
                    rl_next  = rl_digit;
                    cnt_next = cnt_inc[CNT_W-1:0];
                    if (!rx[7])
                    begin
                        finish = (rl_digit == '0);
                    end
                    else if (too_many)
                    begin
                        body_ev_valid     = 1'b1;
                        body_ev.event_res = EV_BAD_LENGTH;
                        halted_next       = 1'b1;
                        connected_next    = 1'b0;
                    end
                end
                PH_BODY:
                begin
                    pos_next = pos_inc[RL_W-1:0];
                    finish   = body_done;
                    case (pkt_type)
                        PKT_PUBLISH:
                        begin
                            if (pos_reg == RL_W'(0))
                            begin
                                topic_next = {rx, 8'h00};
                            end
                            else if (pos_reg == RL_W'(1))
                            begin
                                topic_next  = {topic_reg[15:8], rx};
                                pub_ok_next = need <= CMP_W'(rl_reg);
                            end
                            else if (pub_ok_reg)
                            begin
                                if (pos_ext < tend)
                                begin
                                    body_ev_valid     = 1'b1;
                                    body_ev.event_res = EV_TOPIC_BYTE;
                                    body_ev.data_byte = rx;
                                end
                                else if ((qos != 2'd0) && (pos_ext == tend))
                                begin
                                    pid_next = {rx, 8'h00};
                                end
                                else if ((qos != 2'd0) && (pos_ext == tend_plus1))
                                begin
                                    pid_next = {pid_reg[15:8], rx};
                                    if (qos == 2'd1)
                                    begin
                                        body_ev_valid     = 1'b1;
                                        body_ev.event_res = EV_PUBACK_REQ;
                                        body_ev.packet_id = {pid_reg[15:8], rx};
                                    end
                                end
                                else
                                begin
                                    body_ev_valid     = 1'b1;
                                    body_ev.event_res = EV_PAYLOAD_BYTE;
                                    body_ev.data_byte = rx;
                                end
                            end
                        end
                        PKT_CONNACK:
                        begin
                            if (pos_reg == RL_W'(1))
                            begin
                                code_next = rx;
                            end
                        end
                        PKT_SUBACK:
                        begin
                            if (pos_reg == RL_W'(0))
                            begin
                                pid_next = {rx, 8'h00};
                            end
                            else if (pos_reg == RL_W'(1))
                            begin
                                pid_next = {pid_reg[15:8], rx};
                            end
                            else if (pos_reg == RL_W'(2))
                            begin
                                code_next = rx;
                            end
                        end
                        default:
                        begin
                            pos_next = pos_inc[RL_W-1:0];
                        end
                    endcase
                end
                default:
                begin
                    halted_next = halted_reg;
                end
            endcase

            // The end-of-packet report sees the fields as updated by this byte.
            if (finish)
            begin
                case (pkt_type)
                    PKT_CONNACK:
                    begin
                        fin_ev_valid = 1'b1;
                        if (rl_next < RL_W'(2))
                        begin
                            fin_ev.event_res = EV_BAD_CONNACK;
                            halted_next      = 1'b1;
                            connected_next   = 1'b0;
                        end
                        else if (code_next == 8'h00)
                        begin
                            fin_ev.event_res = EV_CONNACK_OK;
                            connected_next   = 1'b1;
                        end
                        else
                        begin
                            fin_ev.event_res = EV_CONNACK_REFUSED;
                            fin_ev.code      = code_next;
                            halted_next      = 1'b1;
                            connected_next   = 1'b0;
                        end
                    end
                    PKT_PUBLISH:
                    begin
                        fin_ev_valid     = pub_ok_next;
                        fin_ev.event_res = EV_MSG_END;
                    end
                    PKT_SUBACK:
                    begin
                        fin_ev_valid     = rl_next >= RL_W'(3);
                        fin_ev.event_res = (code_next == SUBACK_FAILURE) ?
                                           EV_SUBACK_REFUSED : EV_SUBACK_GRANTED;
                        fin_ev.packet_id = pid_next;
                        fin_ev.code      = code_next;
                    end
                    default:
                    begin
                        fin_ev_valid = 1'b0;
                    end
                endcase
            end
        end

        body_ev.connected = connected_next;
        fin_ev.connected  = connected_next;
    end

    // Pack the results in order; the packet end always comes after the byte's other result.
    always_comb
    begin
        results.count  = 2'(body_ev_valid) + 2'(fin_ev_valid);
        results.first  = body_ev_valid ? body_ev : fin_ev;
        results.second = fin_ev;
        results.first.last  = !(body_ev_valid && fin_ev_valid);
        results.second.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            connected_reg <= 1'b0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            connected_reg <= connected_next;
            halted_reg    <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        header_reg <= header_next;
        rl_reg     <= rl_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        topic_reg  <= topic_next;
        pid_reg    <= pid_next;
        code_reg   <= code_next;
        pub_ok_reg <= pub_ok_next;
    end

    a_halt_drops_connection: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !connected_reg)
        else $error("parser halted while still marked connected");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (phase_reg == PH_HEADER) && !halted_reg && !connected_reg)
        else $error("link restart did not clear the parser");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && halted_reg) |-> (results.count == 2'd0))
        else $error("halted parser produced a result");

endmodule

// ===== rtl/core/mrpp_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and gives one per beat.
module mrpp_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrpp_pkg::result_pair_t push,
    input  logic                   pop,
    output mrpp_pkg::result_t      head,
    output logic                   not_empty,
    output logic                   room
);
    import mrpp_pkg::*;

    localparam int PTR_W = $clog2(RESULT_DEPTH);

    result_t            entry_reg [RESULT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign head         = entry_reg[rd_ptr_reg];
    assign not_empty    = count_reg != '0;
    assign room         = count_reg <= (PTR_W+1)'(RESULT_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room in the queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(RESULT_DEPTH))
        else $error("result queue count out of range");

endmodule

// ===== rtl/core/mqtt_rx_packet_parser_core.sv =====
// Top level of the MQTT 3.1.1 receive packet parser.
//
// The item channel carries one beat per received byte (operation 0) or a link
// restart (operation 1). The result channel carries one result per beat:
// topic and payload bytes, message end, PUBACK requests, CONNACK and SUBACK
// reports, and length or CONNACK errors, with last set on the final result
// that a byte causes.
// A beat that is taken sits in the input register until the queue has room,
// is then parsed, and its results are written into the queue, from whose
// head they are taken. One byte is taken every cycle while each byte causes
// at most one result and the receiver keeps up; a byte that causes two results
// needs two result beats. A four-entry result queue decouples the sides: the
// input register holds while the queue has fewer than two free entries.
// Reset clears the parser to wait for a fixed header, with connected low and
// no queued results. When the receiver stalls, the head result holds and the
// queue fills; item_stall rises once fewer than two entries are free.
module mqtt_rx_packet_parser_core #(
    parameter int LENGTH_DIGITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mrpp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mrpp_pkg::result_t result
);
    import mrpp_pkg::*;

    logic         item_valid_reg, item_valid_next;
    item_t        item_reg;
    logic         room;
    logic         advance;
    logic         accept;
    logic         pop;
    result_pair_t step_results;

    assign advance    = item_valid_reg && room;
    assign item_stall = item_valid_reg && !room;
    assign accept     = item_valid && !item_stall;
    assign pop        = result_valid && !result_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    mrpp_parser #(
        .LENGTH_DIGITS(LENGTH_DIGITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .results (step_results)
    );

    mrpp_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_results),
        .pop       (pop),
        .head      (result),
        .not_empty (result_valid),
        .room      (room)
    );

endmodule
